// ===== src/nrd_pkg.sv =====
// nrd_pkg: widths, stage record type and field conversion helpers for the
// non-restoring divider. No dependencies.
package nrd_pkg;

  localparam int unsigned WIDTH = 16;
  localparam int unsigned FieldW = 16;
  // signed partial remainder: magnitude stays below twice the divisor
  localparam int unsigned RemW = WIDTH + 2;
  localparam int unsigned WideW = (WIDTH > FieldW) ? WIDTH : FieldW;

  typedef struct packed {
    logic signed [RemW-1:0] part;
    logic [WIDTH-1:0]       qreg;
    logic [WIDTH-1:0]       den;
    logic                   dbz;
  } stage_t;

  function automatic logic [WIDTH-1:0] from_field(input logic [FieldW-1:0] f);
    logic [WideW-1:0] tmp;
    tmp = WideW'(f);
    return tmp[WIDTH-1:0];
  endfunction

  function automatic logic [FieldW-1:0] to_field(input logic [WIDTH-1:0] v);
    logic [WideW-1:0] tmp;
    tmp = WideW'(v);
    return tmp[FieldW-1:0];
  endfunction

endpackage

// ===== src/nrd_stage.sv =====
// nrd_stage: one registered non-restoring iteration (shift, add or subtract,
// quotient bit) with elastic handshake. Depends on nrd_pkg.
module nrd_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  nrd_pkg::stage_t in_data_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  output nrd_pkg::stage_t out_data_o,
  input  logic            out_ready_i
);
  import nrd_pkg::*;

  logic            valid_q;
  stage_t          data_q;
  stage_t          data_d;
  logic [RemW-1:0] shifted;
  logic [RemW-1:0] den_ext;
  logic [RemW-1:0] next_part;

  assign den_ext = RemW'(in_data_i.den);
  assign shifted = {in_data_i.part[RemW-2:0], in_data_i.qreg[WIDTH-1]};

  always_comb begin
    // subtract when the previous remainder was non-negative, else add back
    if (!in_data_i.part[RemW-1]) begin
      next_part = shifted - den_ext;
    end else begin
      next_part = shifted + den_ext;
    end
    data_d      = in_data_i;
    data_d.part = next_part;
    data_d.qreg = {in_data_i.qreg[WIDTH-2:0], ~next_part[RemW-1]};
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== src/nrd_fix.sv =====
// nrd_fix: output register with final remainder correction and zero-divisor
// handling. Depends on nrd_pkg.
module nrd_fix (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  nrd_pkg::stage_t            in_data_i,
  output logic                       in_ready_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [nrd_pkg::FieldW-1:0] quotient_o,
  output logic [nrd_pkg::FieldW-1:0] remainder_o,
  output logic                       divide_by_zero_o
);
  import nrd_pkg::*;

  logic              valid_q;
  logic [FieldW-1:0] quo_q;
  logic [FieldW-1:0] rem_q;
  logic              dbz_q;
  logic [FieldW-1:0] quo_d;
  logic [FieldW-1:0] rem_d;
  logic [RemW-1:0]   fixed;

  always_comb begin
    if (in_data_i.part[RemW-1]) begin
      fixed = in_data_i.part + RemW'(in_data_i.den);
    end else begin
      fixed = in_data_i.part;
    end
    if (in_data_i.dbz) begin
      quo_d = '0;
      rem_d = '0;
    end else begin
      quo_d = to_field(in_data_i.qreg);
      rem_d = to_field(fixed[WIDTH-1:0]);
    end
  end

  assign in_ready_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
      dbz_q <= in_data_i.dbz;
    end
  end

  assign out_valid_o      = valid_q;
  assign quotient_o       = quo_q;
  assign remainder_o      = rem_q;
  assign divide_by_zero_o = dbz_q;

endmodule

// ===== src/non_restoring_divider.sv =====
// non_restoring_divider: pipelined unsigned non-restoring divider, one stage
// per quotient bit plus a correction stage. Depends on nrd_pkg, nrd_stage, nrd_fix.
//
//   channel   direction  handshake              payload
//   request   in         in_valid_i/in_stall_o   dividend_i, divisor_i
//   result    out        out_valid_o/out_stall_i quotient_o, remainder_o,
//                                                divide_by_zero_o
//
// one request per cycle while in_stall_o is low; WIDTH iteration stages, each
// one add/subtract of WIDTH + 2 bits, then the correction/output register.
// reset clears every stage valid bit; data registers are not reset.
// a stall fills empty stages first: in_stall_o rises only when every stage
// holds a request, and it follows out_stall_i through the ready chain.
module non_restoring_divider (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [nrd_pkg::FieldW-1:0] dividend_i,
  input  logic [nrd_pkg::FieldW-1:0] divisor_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [nrd_pkg::FieldW-1:0] quotient_o,
  output logic [nrd_pkg::FieldW-1:0] remainder_o,
  output logic                       divide_by_zero_o
);
  import nrd_pkg::*;

  logic [WIDTH:0] stg_valid;
  logic [WIDTH:0] stg_ready;
  stage_t         stg_data [WIDTH+1];

  always_comb begin
    stg_data[0].part = '0;
    stg_data[0].qreg = from_field(dividend_i);
    stg_data[0].den  = from_field(divisor_i);
    stg_data[0].dbz  = (from_field(divisor_i) == '0);
  end
  assign stg_valid[0] = in_valid_i;
  assign in_stall_o   = !stg_ready[0];

  for (genvar k = 0; k < WIDTH; k++) begin : g_stage
    nrd_stage u_stage (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (stg_valid[k]),
      .in_data_i  (stg_data[k]),
      .in_ready_o (stg_ready[k]),
      .out_valid_o(stg_valid[k+1]),
      .out_data_o (stg_data[k+1]),
      .out_ready_i(stg_ready[k+1])
    );
  end

  nrd_fix u_fix (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (stg_valid[WIDTH]),
    .in_data_i       (stg_data[WIDTH]),
    .in_ready_o      (stg_ready[WIDTH]),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .quotient_o      (quotient_o),
    .remainder_o     (remainder_o),
    .divide_by_zero_o(divide_by_zero_o)
  );

  // with no downstream stall every stage can move
  a_no_stall_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output is free");

  // input is only held back when the first stage is occupied
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> stg_valid[1])
    else $error("input stalled with first stage empty");

  a_dbz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && divide_by_zero_o) |-> (quotient_o == '0 && remainder_o == '0))
    else $error("divide by zero result not cleared");

endmodule

// ===== sim/nrd_result_checker.sv =====
`timescale 1ns / 1ps
// nrd_result_checker: watches both channels of the divider, predicts quotient,
// remainder and the zero-divisor flag for each request and counts mismatches.
// Depends on nrd_pkg.
module nrd_result_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic [nrd_pkg::FieldW-1:0] dividend_i,
  input  logic [nrd_pkg::FieldW-1:0] divisor_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic [nrd_pkg::FieldW-1:0] quotient_i,
  input  logic [nrd_pkg::FieldW-1:0] remainder_i,
  input  logic                       divide_by_zero_i,
  output int                         errors_o,
  output int                         pending_o
);
  import nrd_pkg::*;

  typedef struct packed {
    logic [FieldW-1:0] quo;
    logic [FieldW-1:0] rem;
    logic              dbz;
  } quot_rem_t;

  quot_rem_t expected_q[$];

  function automatic quot_rem_t divide_nonrestoring(input logic [FieldW-1:0] n,
                                                    input logic [FieldW-1:0] d);
    quot_rem_t               res;
    logic [63:0]             n64;
    logic [63:0]             d64;
    logic [63:0]             q64;
    logic [WIDTH-1:0]        num;
    logic [WIDTH-1:0]        den;
    logic [WIDTH-1:0]        q;
    logic signed [WIDTH+2:0] part;
    logic signed [WIDTH+2:0] den_ext;
    logic                    was_nonneg;
    n64 = 64'(n);
    d64 = 64'(d);
    num = n64[WIDTH-1:0];
    den = d64[WIDTH-1:0];
    res = '0;
    if (den == '0) begin
      res.dbz = 1'b1;
      return res;
    end
    den_ext = $signed({3'b000, den});
    part    = '0;
    q       = num;
    for (int i = 0; i < WIDTH; i++) begin
      was_nonneg = ~part[WIDTH+2];
      part = {part[WIDTH+1:0], q[WIDTH-1]};
      q    = q << 1;
      if (was_nonneg) begin
        part = part - den_ext;
      end else begin
        part = part + den_ext;
      end
      q[0] = ~part[WIDTH+2];
    end
    // negative remainder gets one more add of the divisor
    if (part[WIDTH+2]) begin
      part = part + den_ext;
    end
    q64     = 64'(q);
    res.quo = q64[FieldW-1:0];
    n64     = 64'(part[WIDTH-1:0]);
    res.rem = n64[FieldW-1:0];
    return res;
  endfunction

  always @(posedge clk_i) begin
    quot_rem_t exp_res;
    if (!rst_ni) begin
      expected_q.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with no request pending: quo=%h rem=%h dbz=%b",
                   $time, quotient_i, remainder_i, divide_by_zero_i);
          errors_o = errors_o + 1;
        end else begin
          exp_res = expected_q.pop_front();
          if (quotient_i !== exp_res.quo) begin
            $display("%0t: quotient mismatch: expected %h, actual %h",
                     $time, exp_res.quo, quotient_i);
            errors_o = errors_o + 1;
          end
          if (remainder_i !== exp_res.rem) begin
            $display("%0t: remainder mismatch: expected %h, actual %h",
                     $time, exp_res.rem, remainder_i);
            errors_o = errors_o + 1;
          end
          if (divide_by_zero_i !== exp_res.dbz) begin
            $display("%0t: divide_by_zero mismatch: expected %b, actual %b",
                     $time, exp_res.dbz, divide_by_zero_i);
            errors_o = errors_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_q.push_back(divide_nonrestoring(dividend_i, divisor_i));
      end
      pending_o = expected_q.size();
    end
  end

endmodule

// ===== sim/tb_non_restoring_divider.sv =====
`timescale 1ns / 1ps
// tb_non_restoring_divider: drives directed and random division requests with
// random idling on both sides and gives the verdict from nrd_result_checker.
// Depends on nrd_pkg, non_restoring_divider and nrd_result_checker.
module tb_non_restoring_divider;
  import nrd_pkg::*;

  localparam int NumDirected = 20;
  localparam int NumRandom   = 1650;
  localparam int IdlePct     = 19;
  localparam int HoldCycles  = 80;
  localparam int StuckLimit  = 5000;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [FieldW-1:0] dividend;
  logic [FieldW-1:0] divisor;
  logic              out_valid;
  logic              out_stall;
  logic [FieldW-1:0] quotient;
  logic [FieldW-1:0] remainder;
  logic              divide_by_zero;
  int                errors;
  int                pending;

  // both sides stop idling while steady is set
  logic steady   = 1'b0;
  logic hold_req = 1'b0;

  logic [FieldW-1:0] dir_n [NumDirected] = '{
    16'h0000, 16'hffff, 16'h1234, 16'h0000, 16'hffff, 16'hffff, 16'h0000,
    16'hfffe, 16'h8000, 16'h8000, 16'h7fff, 16'hffff, 16'hffff, 16'h0001,
    16'haaaa, 16'h5555, 16'hffff, 16'h0064, 16'hc350, 16'h0001
  };
  logic [FieldW-1:0] dir_d [NumDirected] = '{
    16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0001, 16'hffff, 16'hffff,
    16'hffff, 16'h0001, 16'h8000, 16'h8000, 16'h8000, 16'h0002, 16'h0001,
    16'h5555, 16'haaaa, 16'h7fff, 16'h0003, 16'h00c8, 16'h0002
  };

  non_restoring_divider dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .dividend_i      (dividend),
    .divisor_i       (divisor),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .quotient_o      (quotient),
    .remainder_o     (remainder),
    .divide_by_zero_o(divide_by_zero)
  );

  nrd_result_checker checker_i (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .dividend_i      (dividend),
    .divisor_i       (divisor),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .quotient_i      (quotient),
    .remainder_i     (remainder),
    .divide_by_zero_i(divide_by_zero),
    .errors_o        (errors),
    .pending_o       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // mix of zero, small, large and full-range divisors
  task automatic next_pair(output logic [FieldW-1:0] n, output logic [FieldW-1:0] d);
    int unsigned pick;
    pick = $urandom_range(99);
    n = FieldW'($urandom);
    if (pick < 8) begin
      d = '0;
    end else if (pick < 30) begin
      d = FieldW'($urandom_range(15, 1));
    end else if (pick < 45) begin
      d = FieldW'($urandom) | 16'h8000;
      n = n >> $urandom_range(15);
    end else if (pick < 55) begin
      d = FieldW'($urandom) >> $urandom_range(15);
      if (d == '0) begin
        d = 16'h0001;
      end
    end else begin
      d = FieldW'($urandom);
    end
  endtask

  initial begin
    logic [FieldW-1:0] n;
    logic [FieldW-1:0] d;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    dividend <= '0;
    divisor  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int k = 0; k < NumDirected + NumRandom; k++) begin
      if (k < NumDirected) begin
        n = dir_n[k];
        d = dir_d[k];
      end else begin
        next_pair(n, d);
      end
      steady = (k >= 800) && (k < 1100);
      if (k == 400) begin
        hold_req = 1'b1;
      end
      while (!steady && $urandom_range(99) < IdlePct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid <= 1'b1;
      dividend <= n;
      divisor  <= d;
      // inputs only move at the rising edge, so the falling edge shows the
      // stall that the next rising edge will see
      do @(negedge clk); while (in_stall);
      @(posedge clk);
    end
    in_valid <= 1'b0;
    steady = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (WIDTH + 8) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // result side: random stalls and one long hold-off to back up the pipeline
  initial begin
    logic held;
    held = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HoldCycles - 1) @(posedge clk);
      end else if (steady) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < IdlePct);
      end
    end
  end

  initial begin
    int stuck;
    stuck = 0;
    while (stuck < StuckLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        stuck = 0;
      end else begin
        stuck++;
      end
    end
    $display("%0t: no request or result moved for %0d cycles", $time, StuckLimit);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
src/nrd_pkg.sv
src/nrd_stage.sv
src/nrd_fix.sv
src/non_restoring_divider.sv
sim/nrd_result_checker.sv
sim/tb_non_restoring_divider.sv
